// ===== rtl/llp_pkg.sv =====
// Shared types and constants for the LL(1) predictive parser.
// No dependencies.
package llp_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_START = 2'd2,
        ACT_TOKEN = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CONSUMED = 3'd1,
        ST_ACCEPT   = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_NOPROD   = 3'd4,
        ST_LEFTOVER = 3'd5,
        ST_OVERFLOW = 3'd6,
        ST_FULL     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RUNNING = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        EX_IDLE,
        EX_DISPATCH,
        EX_SEARCH,
        EX_SRCH_WAIT,
        EX_TOP_RD,
        EX_TOP_WAIT,
        EX_DECIDE,
        EX_ENT_WAIT,
        EX_EXPAND,
        EX_PUSH,
        EX_RESULT
    } exec_state_t;

    localparam logic [0:0] CFG_START_SYMBOL = 1'b0;
    localparam logic [0:0] CFG_END_MARKER   = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  symbol;
        logic [7:0]  lookahead;
        logic [63:0] production;
        logic [3:0]  production_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] stack_depth;
    } out_item_t;

endpackage

// ===== rtl/ll1_predictive_parser.sv =====
// Top level of the LL(1) predictive parser: front queue, back sequencer, config registers.
// Depends on llp_pkg, llp_queue and llp_exec.
//
// Table-driven LL(1) recognizer. Each input beat is one item (load entry, clear table,
// start parse or token) and gives exactly one result beat with a status and the stack
// depth. Input beats enter a two-entry queue so the input side keeps flowing while the
// sequencer works or a result waits. The sequencer handles one item at a time. A load
// first searches for a duplicate entry, reading the single-port table memory one entry
// at a time; clear and start need no search. A token reads and matches the stack top;
// every expansion adds a table search, an entry fetch and a fresh read of the stack top,
// and the production's symbols are pushed one per cycle. The table and the symbol stack
// are single-port memories with registered reads; they need no clearing pass.
module ll1_predictive_parser #(
    parameter int TABLE_ENTRIES      = 64,
    parameter int STACK_DEPTH        = 256,
    parameter int PRODUCTION_SYMBOLS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  llp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output llp_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import llp_pkg::*;

    logic       cfg_is_start;
    logic [7:0] start_sym_reg;
    logic [7:0] end_marker_reg;
    logic       q_valid;
    logic       q_ready;
    in_item_t   q_data;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_is_start = (cfg_index == CFG_START_SYMBOL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_sym_reg  <= 8'd0;
            end_marker_reg <= 8'd36;
        end
        else if (cfg_valid)
        begin
            if (cfg_is_start)
            begin
                start_sym_reg <= cfg_data;
            end
            else
            begin
                end_marker_reg <= cfg_data;
            end
        end
    end

    llp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (in_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    llp_exec #(
        .TABLE_ENTRIES      (TABLE_ENTRIES),
        .STACK_DEPTH        (STACK_DEPTH),
        .PRODUCTION_SYMBOLS (PRODUCTION_SYMBOLS)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_item      (q_data),
        .res_valid    (out_valid),
        .res_ready    (out_ready),
        .res_item     (out_data),
        .start_symbol (start_sym_reg),
        .end_marker   (end_marker_reg)
    );

endmodule

// ===== rtl/llp_queue.sv =====
// Small first-in first-out queue of input beats between the front and the back part.
// Depends on llp_pkg.
module llp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  llp_pkg::in_item_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output llp_pkg::in_item_t rd_data
);
    import llp_pkg::*;

    in_item_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a push");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue count missed a pop");

endmodule

// ===== rtl/llp_exec.sv =====
// Back part: parse table, symbol stack and the sequencer that runs each item.
// Depends on llp_pkg.
module llp_exec #(
    parameter int TABLE_ENTRIES      = 64,
    parameter int STACK_DEPTH        = 256,
    parameter int PRODUCTION_SYMBOLS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  llp_pkg::in_item_t  in_item,
    output logic               res_valid,
    input  logic               res_ready,
    output llp_pkg::out_item_t res_item,
    input  logic [7:0]         start_symbol,
    input  logic [7:0]         end_marker
);
    import llp_pkg::*;

    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int LW = 4;
    localparam int PB = 8 * PRODUCTION_SYMBOLS;

    // Table memory: nonterminal, lookahead, production, length.
    localparam int EW = 16 + PB + LW;
    logic [EW-1:0] table_mem [TABLE_ENTRIES];
    logic [EW-1:0] tab_rd_reg;
    logic [TW-1:0] tab_addr;
    logic          tab_we;
    logic [EW-1:0] tab_wdata;

    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    stk_rd_reg;
    logic [SW-1:0] stk_addr;
    logic          stk_we;
    logic [7:0]    stk_wdata;

    exec_state_t   state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          known_reg, known_next;
    logic          hit_reg, hit_next;
    logic [TW-1:0] hit_idx_reg, hit_idx_next;
    logic [CW:0]   chain_reg, chain_next;
    logic [LW-1:0] push_k_reg, push_k_next;
    logic [2:0]    status_reg, status_next;
    logic          res_valid_reg, res_valid_next;
    logic [8:0]    res_depth_reg, res_depth_next;
    in_item_t      item_reg, item_next;
    logic          item_take;
    logic [7:0]    key_nt, key_la;
    logic [7:0]    ent_nt, ent_la;
    logic [PB-1:0] ent_prod;
    logic [LW-1:0] ent_len;
    logic [LW-1:0] load_len;
    logic [PW:0]   grow;
    logic [2:0]    push_sel;

    assign ent_nt   = tab_rd_reg[EW-1 -: 8];
    assign ent_la   = tab_rd_reg[EW-9 -: 8];
    assign ent_prod = tab_rd_reg[LW +: PB];
    assign ent_len  = tab_rd_reg[LW-1:0];
    assign load_len = (item_reg.production_length > LW'(PRODUCTION_SYMBOLS)) ?
                      LW'(PRODUCTION_SYMBOLS) : item_reg.production_length;
    assign key_nt   = (item_reg.action == ACT_LOAD) ? item_reg.symbol : stk_rd_reg;
    assign key_la   = (item_reg.action == ACT_LOAD) ? item_reg.lookahead : item_reg.symbol;
    assign grow     = {1'b0, sp_reg} - (PW+1)'(1) + (PW+1)'(ent_len);
    assign push_sel = 3'(push_k_reg - LW'(1));

    assign in_ready  = (state_reg == EX_IDLE) && !res_valid_reg;
    assign item_take = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res_item.status      = status_reg;
    assign res_item.stack_depth = res_depth_reg;

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            table_mem[tab_addr] <= tab_wdata;
        end
        tab_rd_reg <= table_mem[tab_addr];
        if (stk_we)
        begin
            stack_mem[stk_addr] <= stk_wdata;
        end
        stk_rd_reg <= stack_mem[stk_addr];
        item_reg   <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EX_IDLE;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            sp_reg        <= '0;
            idx_reg       <= '0;
            known_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            chain_reg     <= '0;
            push_k_reg    <= '0;
            status_reg    <= ST_OK;
            res_valid_reg <= 1'b0;
            res_depth_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            idx_reg       <= idx_next;
            known_reg     <= known_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            chain_reg     <= chain_next;
            push_k_reg    <= push_k_next;
            status_reg    <= status_next;
            res_valid_reg <= res_valid_next;
            res_depth_reg <= res_depth_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EX_IDLE:
            begin
                if (item_take)
                begin
                    state_next = EX_DISPATCH;
                end
            end
            EX_DISPATCH:
            begin
                case (item_reg.action)
                    ACT_LOAD:  state_next = EX_SEARCH;
                    ACT_TOKEN: state_next = (phase_reg == PH_RUNNING) ? EX_TOP_RD : EX_RESULT;
                    default:   state_next = EX_RESULT;
                endcase
            end
            EX_TOP_RD:   state_next = EX_TOP_WAIT;
            EX_TOP_WAIT:
            begin
                if (sp_reg == '0 || stk_rd_reg == end_marker || stk_rd_reg == item_reg.symbol)
                begin
                    state_next = EX_RESULT;
                end
                else
                begin
                    state_next = EX_SEARCH;
                end
            end
            EX_SEARCH:
            begin
                if (idx_reg >= count_reg || hit_reg)
                begin
                    state_next = (item_reg.action == ACT_LOAD) ? EX_RESULT : EX_DECIDE;
                end
                else
                begin
                    state_next = EX_SRCH_WAIT;
                end
            end
            EX_SRCH_WAIT: state_next = EX_SEARCH;
            EX_DECIDE:    state_next = hit_reg ? EX_ENT_WAIT : EX_RESULT;
            EX_ENT_WAIT:  state_next = EX_EXPAND;
            EX_EXPAND:
            begin
                if (grow > (PW+1)'(STACK_DEPTH) ||
                    (ent_len != '0 && chain_reg + 1'b1 > {1'b0, count_reg}))
                begin
                    state_next = EX_RESULT;
                end
                else if (ent_len == '0)
                begin
                    state_next = EX_TOP_RD;
                end
                else
                begin
                    state_next = EX_PUSH;
                end
            end
            EX_PUSH:   state_next = (push_k_reg == LW'(1)) ? EX_TOP_RD : EX_PUSH;
            EX_RESULT: state_next = EX_IDLE;
            default:   state_next = EX_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        idx_next       = idx_reg;
        known_next     = known_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        chain_next     = chain_reg;
        push_k_next    = push_k_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;
        res_depth_next = res_depth_reg;
        item_next      = item_reg;
        tab_we         = 1'b0;
        tab_addr       = idx_reg[TW-1:0];
        tab_wdata      = {item_reg.symbol, item_reg.lookahead,
                          item_reg.production[PB-1:0], load_len};
        stk_we         = 1'b0;
        stk_addr       = sp_reg[SW-1:0] - 1'b1;
        stk_wdata      = ent_prod[8*push_sel +: 8];

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            EX_IDLE:
            begin
                if (item_take)
                begin
                    item_next   = in_item;
                    status_next = ST_OK;
                    idx_next    = '0;
                    known_next  = 1'b0;
                    hit_next    = 1'b0;
                    chain_next  = '0;
                end
            end
            EX_DISPATCH:
            begin
                case (item_reg.action)
                    ACT_CLEAR: count_next = '0;
                    ACT_START:
                    begin
                        stk_we    = 1'b1;
                        stk_addr  = '0;
                        stk_wdata = end_marker;
                    end
                    ACT_TOKEN:
                    begin
                        if (phase_reg != PH_RUNNING)
                        begin
                            status_next = ST_LEFTOVER;
                        end
                    end
                    default: ;
                endcase
            end
            EX_TOP_WAIT:
            begin
                idx_next   = '0;
                known_next = 1'b0;
                hit_next   = 1'b0;
                if (sp_reg == '0 || stk_rd_reg == end_marker)
                begin
                    phase_next  = PH_DONE;
                    status_next = (item_reg.symbol == end_marker) ? ST_ACCEPT : ST_LEFTOVER;
                end
                else if (stk_rd_reg == item_reg.symbol)
                begin
                    sp_next     = sp_reg - 1'b1;
                    status_next = ST_CONSUMED;
                end
            end
            EX_SEARCH:
            begin
                if (idx_reg >= count_reg || hit_reg)
                begin
                    if (item_reg.action == ACT_LOAD && !hit_reg)
                    begin
                        if (count_reg >= CW'(TABLE_ENTRIES))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            tab_we     = 1'b1;
                            tab_addr   = count_reg[TW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            EX_SRCH_WAIT:
            begin
                if (ent_nt == key_nt)
                begin
                    known_next = 1'b1;
                    if (ent_la == key_la)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = idx_reg[TW-1:0];
                    end
                end
                idx_next = idx_reg + 1'b1;
            end
            EX_DECIDE:
            begin
                tab_addr = hit_idx_reg;
                if (!hit_reg)
                begin
                    phase_next  = PH_DONE;
                    status_next = known_reg ? ST_NOPROD : ST_MISMATCH;
                end
            end
            EX_ENT_WAIT:
            begin
                // Keep the matching entry on the read port while it is expanded.
                tab_addr = hit_idx_reg;
            end
            EX_EXPAND:
            begin
                tab_addr = hit_idx_reg;
                if (grow > (PW+1)'(STACK_DEPTH) ||
                    (ent_len != '0 && chain_reg + 1'b1 > {1'b0, count_reg}))
                begin
                    phase_next  = PH_DONE;
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    chain_next  = (ent_len == '0) ? '0 : chain_reg + 1'b1;
                    sp_next     = sp_reg - 1'b1;
                    push_k_next = ent_len;
                end
            end
            EX_PUSH:
            begin
                tab_addr    = hit_idx_reg;
                stk_we      = 1'b1;
                stk_addr    = sp_reg[SW-1:0];
                sp_next     = sp_reg + 1'b1;
                push_k_next = push_k_reg - 1'b1;
            end
            EX_RESULT:
            begin
                if (item_reg.action == ACT_START)
                begin
                    stk_we      = 1'b1;
                    stk_addr    = SW'(1);
                    stk_wdata   = start_symbol;
                    sp_next     = PW'(2);
                    phase_next  = PH_RUNNING;
                    res_depth_next = 9'd2;
                end
                else
                begin
                    res_depth_next = 9'(sp_reg);
                end
                res_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |=> res_valid_reg && $stable(status_reg))
        else $error("pending result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, sp_reg} <= (PW+1)'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("table count beyond size");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == EX_PUSH |-> push_k_reg != '0)
        else $error("push with nothing left");

endmodule
